/* design/nte_pkg.sv */
package nte_pkg;

  localparam int unsigned DefaultCapacity = 16;

  typedef enum logic [3:0] {
    ACT_UPSERT     = 4'd0,
    ACT_FIND_SHORT = 4'd1,
    ACT_FIND_LONG  = 4'd2,
    ACT_REM_SHORT  = 4'd3,
    ACT_REM_OLDER  = 4'd4,
    ACT_REM_STALE  = 4'd5,
    ACT_BEST       = 4'd6,
    ACT_COUNT      = 4'd7,
    ACT_CLEAR      = 4'd8
  } action_t;

  localparam logic [1:0] CFG_SLOTS = 2'd0;
  localparam logic [1:0] CFG_COORD = 2'd1;
  localparam logic [1:0] CFG_ROUTER = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic done;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
    logic out_valid;
  } status_t;

endpackage

/* design/nte_ctrl.sv */
module nte_ctrl
  import nte_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: cmd.scan = 1'b1;
      ST_WRITE: cmd.write = 1'b1;
      ST_OUT: cmd.done = !out_stall;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    status.out_valid == (state == ST_OUT)) else $error("out_valid mismatch");
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && status.scan_last) |=> state == ST_WRITE)
    else $error("scan did not end");
  a_write_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> state == ST_OUT) else $error("write not followed by output");
`endif

endmodule

/* design/nte_datapath.sv */
module nte_datapath
  import nte_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic [3:0]  action,
  input  logic [15:0] short_address,
  input  logic [63:0] long_address,
  input  logic [1:0]  kind,
  input  logic [2:0]  relation,
  input  logic [3:0]  tree_depth,
  input  logic [7:0]  link_quality,
  input  logic        receiver_on,
  input  logic        joining_open,
  input  logic [31:0] time_ms,
  output logic        hit,
  output logic [3:0]  slot_index,
  output logic [15:0] entry_short,
  output logic [63:0] entry_long,
  output logic [1:0]  entry_kind,
  output logic [2:0]  entry_relation,
  output logic [3:0]  entry_depth,
  output logic [7:0]  entry_quality,
  output logic        entry_receiver_on,
  output logic        entry_joining_open,
  output logic [31:0] entry_last_seen,
  output logic [4:0]  tally
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0] used;
  logic [15:0] s_short [CAPACITY];
  logic [63:0] s_long [CAPACITY];
  logic [1:0]  s_kind [CAPACITY];
  logic [2:0]  s_rel [CAPACITY];
  logic [3:0]  s_depth [CAPACITY];
  logic [7:0]  s_qual [CAPACITY];
  logic        s_rx [CAPACITY];
  logic        s_join [CAPACITY];
  logic [31:0] s_seen [CAPACITY];

  logic [4:0] slots_in_use;
  logic [1:0] coord_code, router_code;

  // Latched item.
  action_t     act;
  logic [15:0] k_short;
  logic [63:0] k_long;
  logic [1:0]  k_kind;
  logic [2:0]  k_rel;
  logic [3:0]  k_depth;
  logic [7:0]  k_qual;
  logic        k_rx, k_join;
  logic [31:0] k_time;

  logic [CW-1:0] n_act;
  logic [IW-1:0] idx;
  logic          scan_any;

  // Scan results: each a found flag and a slot.
  logic          f_short, f_long, f_free, f_old, f_best;
  logic [IW-1:0] i_short, i_long, i_free, i_old, i_best;
  logic [4:0]    cnt;
  logic          out_valid;

  assign n_act = (32'(slots_in_use) < CAPACITY) ? CW'(slots_in_use) : CW'(CAPACITY);
  assign status.scan_last = (n_act == '0) || (CW'(idx) == n_act - CW'(1));
  assign status.out_valid = out_valid;

  // With no active slots the scan must not touch slot zero.
  assign scan_any = (n_act != '0);

  logic is_parent, older, cur_used;
  assign cur_used  = used[idx];
  assign is_parent = (s_kind[idx] == coord_code) || (s_kind[idx] == router_code);
  assign older     = s_seen[idx] < k_time;

  logic bulk_kill;
  always_comb begin
    bulk_kill = 1'b0;
    if (scan_any && cur_used && older) begin
      if (act == ACT_REM_OLDER) bulk_kill = 1'b1;
      if (act == ACT_REM_STALE && s_short[idx] != k_short && is_parent) bulk_kill = 1'b1;
    end
  end

  // Slot that the write stage touches and whether it exists.
  logic          w_found;
  logic [IW-1:0] w_idx;
  always_comb begin
    w_found = 1'b0;
    w_idx   = '0;
    case (act)
      ACT_UPSERT: begin
        if (f_short) begin
          w_found = 1'b1; w_idx = i_short;
        end else if (f_long && k_long != '0) begin
          w_found = 1'b1; w_idx = i_long;
        end else if (f_free) begin
          w_found = 1'b1; w_idx = i_free;
        end else begin
          w_found = f_old; w_idx = i_old;
        end
      end
      ACT_FIND_SHORT, ACT_REM_SHORT: begin
        w_found = f_short; w_idx = i_short;
      end
      ACT_FIND_LONG: begin
        w_found = f_long; w_idx = i_long;
      end
      ACT_BEST: begin
        w_found = f_best; w_idx = i_best;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= 5'd16;
      coord_code   <= 2'd0;
      router_code  <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOTS:  slots_in_use <= cfg_data;
        CFG_COORD:  coord_code <= cfg_data[1:0];
        CFG_ROUTER: router_code <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        s_short[i] <= '0; s_long[i] <= '0; s_kind[i] <= '0; s_rel[i] <= '0;
        s_depth[i] <= '0; s_qual[i] <= '0; s_rx[i] <= 1'b0; s_join[i] <= 1'b0;
        s_seen[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        act <= action_t'(action);
        k_short <= short_address; k_long <= long_address; k_kind <= kind;
        k_rel <= relation; k_depth <= tree_depth; k_qual <= link_quality;
        k_rx <= receiver_on; k_join <= joining_open; k_time <= time_ms;
        idx <= '0;
        f_short <= 1'b0; f_long <= 1'b0; f_free <= 1'b0; f_old <= 1'b0;
        f_best <= 1'b0; cnt <= '0;
        i_short <= '0; i_long <= '0; i_free <= '0; i_old <= '0; i_best <= '0;
      end
      if (cmd.scan) begin
        if (scan_any) begin
          if (cur_used && s_short[idx] == k_short && !f_short) begin
            f_short <= 1'b1; i_short <= idx;
          end
          if (cur_used && s_long[idx] == k_long && !f_long) begin
            f_long <= 1'b1; i_long <= idx;
          end
          if (!cur_used && !f_free) begin
            f_free <= 1'b1; i_free <= idx;
          end
          if (!f_old || s_seen[idx] < s_seen[i_old]) begin
            f_old <= 1'b1; i_old <= idx;
          end
          if (cur_used && s_join[idx] && is_parent &&
              (!f_best || s_qual[idx] > s_qual[i_best] ||
               (s_qual[idx] == s_qual[i_best] && s_depth[idx] < s_depth[i_best]))) begin
            f_best <= 1'b1; i_best <= idx;
          end
          if ((act == ACT_COUNT && cur_used) || bulk_kill) cnt <= cnt + 5'd1;
          if (bulk_kill || act == ACT_CLEAR) begin
            used[idx] <= 1'b0;
            s_short[idx] <= '0; s_long[idx] <= '0; s_kind[idx] <= '0;
            s_rel[idx] <= '0; s_depth[idx] <= '0; s_qual[idx] <= '0;
            s_rx[idx] <= 1'b0; s_join[idx] <= 1'b0; s_seen[idx] <= '0;
          end
          if (!status.scan_last) idx <= idx + IW'(1);
        end
      end
      if (cmd.write) begin
        out_valid <= 1'b1;
        hit <= (act == ACT_REM_OLDER || act == ACT_REM_STALE) ? (cnt != '0) : w_found;
        slot_index <= w_found ? 4'(32'(w_idx)) : 4'd0;
        tally <= (act == ACT_COUNT || act == ACT_REM_OLDER || act == ACT_REM_STALE)
                 ? cnt : 5'd0;
        if (w_found && act == ACT_UPSERT) begin
          entry_short <= k_short; entry_long <= k_long; entry_kind <= k_kind;
          entry_relation <= k_rel; entry_depth <= k_depth; entry_quality <= k_qual;
          entry_receiver_on <= k_rx; entry_joining_open <= k_join;
          entry_last_seen <= k_time;
          used[w_idx] <= 1'b1;
          s_short[w_idx] <= k_short; s_long[w_idx] <= k_long; s_kind[w_idx] <= k_kind;
          s_rel[w_idx] <= k_rel; s_depth[w_idx] <= k_depth; s_qual[w_idx] <= k_qual;
          s_rx[w_idx] <= k_rx; s_join[w_idx] <= k_join; s_seen[w_idx] <= k_time;
        end else if (w_found) begin
          entry_short <= s_short[w_idx]; entry_long <= s_long[w_idx];
          entry_kind <= s_kind[w_idx]; entry_relation <= s_rel[w_idx];
          entry_depth <= s_depth[w_idx]; entry_quality <= s_qual[w_idx];
          entry_receiver_on <= s_rx[w_idx]; entry_joining_open <= s_join[w_idx];
          entry_last_seen <= s_seen[w_idx];
          if (act == ACT_REM_SHORT) begin
            used[w_idx] <= 1'b0;
            s_short[w_idx] <= '0; s_long[w_idx] <= '0; s_kind[w_idx] <= '0;
            s_rel[w_idx] <= '0; s_depth[w_idx] <= '0; s_qual[w_idx] <= '0;
            s_rx[w_idx] <= 1'b0; s_join[w_idx] <= 1'b0; s_seen[w_idx] <= '0;
          end
        end else begin
          entry_short <= '0; entry_long <= '0; entry_kind <= '0;
          entry_relation <= '0; entry_depth <= '0; entry_quality <= '0;
          entry_receiver_on <= 1'b0; entry_joining_open <= 1'b0;
          entry_last_seen <= '0;
        end
      end
      if (cmd.done) out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= CAPACITY) else $error("tally overflow");
  a_hit_tally: assert property (@(posedge clk) disable iff (rst)
    (out_valid && act == ACT_COUNT) |-> !hit) else $error("count gave hit");
  a_upsert_used: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && act == ACT_UPSERT && w_found) |=> used[$past(w_idx)])
    else $error("upsert slot not marked used");
`endif

endmodule

/* design/neighbor_table_engine.sv */
// Channel  Direction  Handshake          Content
// in       input      in_valid/in_stall  one action item
// out      output     out_valid/out_stall one result item
// cfg      input      cfg_valid/cfg_ready register index and data
// An item steps through load, a sequential scan of the active slots,
// a write-back, and output.
// Reset clears the whole table at once and loads register defaults.
// A stalled result holds the block; no new item is taken until it leaves.
module neighbor_table_engine
  import nte_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [15:0] short_address,
  input  logic [63:0] long_address,
  input  logic [1:0]  kind,
  input  logic [2:0]  relation,
  input  logic [3:0]  tree_depth,
  input  logic [7:0]  link_quality,
  input  logic        receiver_on,
  input  logic        joining_open,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [3:0]  slot_index,
  output logic [15:0] entry_short,
  output logic [63:0] entry_long,
  output logic [1:0]  entry_kind,
  output logic [2:0]  entry_relation,
  output logic [3:0]  entry_depth,
  output logic [7:0]  entry_quality,
  output logic        entry_receiver_on,
  output logic        entry_joining_open,
  output logic [31:0] entry_last_seen,
  output logic [4:0]  tally,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;
  assign out_valid = status.out_valid;

  nte_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  nte_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .action(action), .short_address(short_address), .long_address(long_address),
    .kind(kind), .relation(relation), .tree_depth(tree_depth),
    .link_quality(link_quality), .receiver_on(receiver_on),
    .joining_open(joining_open), .time_ms(time_ms),
    .hit(hit), .slot_index(slot_index), .entry_short(entry_short),
    .entry_long(entry_long), .entry_kind(entry_kind),
    .entry_relation(entry_relation), .entry_depth(entry_depth),
    .entry_quality(entry_quality), .entry_receiver_on(entry_receiver_on),
    .entry_joining_open(entry_joining_open), .entry_last_seen(entry_last_seen),
    .tally(tally)
  );

endmodule
